FILE: design/v2n_pkg.sv
// v2n_pkg: types, stage counts and step functions for vector2_normalize
// no dependencies; imported by design/vector2_normalize.sv
`default_nettype none

package v2n_pkg;

	localparam int unsigned COMP_W         = 16;
	localparam int unsigned SUM_W          = 2 * COMP_W;
	localparam int unsigned LEN_W          = 16;
	localparam int unsigned REM_W          = LEN_W + 3;
	localparam int unsigned QUO_W          = 15;
	localparam int unsigned FRAC_BITS      = 14;

	localparam int unsigned SQRT_STEPS     = SUM_W / 2;
	localparam int unsigned SQRT_PER_STAGE = 2;
	localparam int unsigned SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	localparam int unsigned DIV_STEPS      = QUO_W;
	localparam int unsigned DIV_PER_STAGE  = 3;
	localparam int unsigned DIV_STAGES     = DIV_STEPS / DIV_PER_STAGE;

	localparam int unsigned FRONT_STAGES   = 3;
	localparam int unsigned NUM_STAGES     = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

	typedef struct packed {
		logic              sx;
		logic              sy;
		logic [COMP_W-1:0] ax;
		logic [COMP_W-1:0] ay;
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [LEN_W-1:0]  root;
	} rt_t;

	typedef struct packed {
		logic              sx;
		logic              sy;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  rem_x;
		logic [LEN_W-1:0]  rem_y;
		logic [QUO_W-1:0]  num_x;
		logic [QUO_W-1:0]  num_y;
		logic [QUO_W-1:0]  q_x;
		logic [QUO_W-1:0]  q_y;
	} dv_t;

	// one result bit of the square root
	function automatic rt_t sqrt_step(input rt_t st);
		rt_t              r;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		r     = st;
		t     = {st.rem[REM_W-3:0], st.rad[SUM_W-1 -: 2]};
		trial = {1'b0, st.root, 2'b01};
		if (t >= trial) begin
			r.rem  = t - trial;
			r.root = {st.root[LEN_W-2:0], 1'b1};
		end else begin
			r.rem  = t;
			r.root = {st.root[LEN_W-2:0], 1'b0};
		end
		r.rad = {st.rad[SUM_W-3:0], 2'b00};
		return r;
	endfunction

	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic             qbit;
	} dstep_t;

	// one quotient bit of a restoring division
	function automatic dstep_t div_bit(input logic [LEN_W-1:0] rem, input logic nb,
		input logic [LEN_W-1:0] len);
		dstep_t         r;
		logic [LEN_W:0] t;
		t = {rem, nb};
		if (t >= {1'b0, len}) begin
			r.rem  = LEN_W'(t - {1'b0, len});
			r.qbit = 1'b1;
		end else begin
			r.rem  = t[LEN_W-1:0];
			r.qbit = 1'b0;
		end
		return r;
	endfunction

	function automatic dv_t div_step(input dv_t st);
		dv_t    r;
		dstep_t bx;
		dstep_t by;
		r       = st;
		bx      = div_bit(st.rem_x, st.num_x[QUO_W-1], st.len);
		by      = div_bit(st.rem_y, st.num_y[QUO_W-1], st.len);
		r.rem_x = bx.rem;
		r.rem_y = by.rem;
		r.q_x   = {st.q_x[QUO_W-2:0], bx.qbit};
		r.q_y   = {st.q_y[QUO_W-2:0], by.qbit};
		r.num_x = {st.num_x[QUO_W-2:0], 1'b0};
		r.num_y = {st.num_y[QUO_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/vector2_normalize.sv
// vector2_normalize: pipelined 2D vector normalization to signed Q1.14
// depends on v2n_pkg (stage counts, stage types, square root and divide steps)
//
// channel   signals                                            direction
// in        in_valid, in_ready, x_component, y_component       request in
// out       out_valid, out_ready, unit_x, unit_y, length,
//           null_error                                         request out
// cfg       cfg_valid, cfg_ready, cfg_wdata (null_limit)       write in
//
// one request per cycle while the output is not stalled; stages: abs, two squarers, sum,
// 8 square root stages of 2 bits each, 5 divider stages of 3 quotient bits each
// (both components in parallel), then the null check and sign stage.
// reset clears the stage valid bits and null_limit; data registers are not reset.
// a stage holds while the stage after it is full and stalled; ready ripples back
// stage by stage, so empty stages keep filling while the output waits.
`default_nettype none

module vector2_normalize
	import v2n_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [COMP_W-1:0] x_component,
	input  wire logic signed [COMP_W-1:0] y_component,

	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [COMP_W-1:0]      unit_x,
	output logic signed [COMP_W-1:0]      unit_y,
	output logic        [LEN_W-1:0]       length,
	output logic                          null_error,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic   [LEN_W-1:0]       cfg_wdata
);

	localparam int unsigned SQ_FIRST  = FRONT_STAGES + 1;
	localparam int unsigned DIV_FIRST = SQ_FIRST + SQRT_STAGES;

	logic [LEN_W-1:0] null_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_limit_q <= '0;
		end else if (cfg_valid) begin
			null_limit_q <= cfg_wdata;
		end
	end

	// pipeline control
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES-1:0] vld_in;
	logic [NUM_STAGES+1:1] rdy;
	logic [NUM_STAGES:1]   ld;

	assign vld_in[0]              = in_valid;
	assign vld_in[NUM_STAGES-1:1] = vld_q[NUM_STAGES-1:1];
	assign rdy[NUM_STAGES+1]      = out_ready;
	assign in_ready               = rdy[1];
	assign out_valid              = vld_q[NUM_STAGES];

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_ctl
		assign rdy[k] = !vld_q[k] || rdy[k+1];
		assign ld[k]  = rdy[k] && vld_in[k-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= vld_in[k-1];
			end
		end
	end

	// front: magnitudes, squares, sum
	logic              sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [COMP_W-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic [SUM_W-1:0]  sqx_s2, sqy_s2, sum_s3;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			sx_s1 <= x_component[COMP_W-1];
			sy_s1 <= y_component[COMP_W-1];
			ax_s1 <= x_component[COMP_W-1] ? COMP_W'(-x_component) : COMP_W'(x_component);
			ay_s1 <= y_component[COMP_W-1] ? COMP_W'(-y_component) : COMP_W'(y_component);
		end
		if (ld[2]) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
		end
		if (ld[3]) begin
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// square root stages
	rt_t rt_in;
	rt_t rt_s [1:SQRT_STAGES];

	always_comb begin
		rt_in      = '0;
		rt_in.sx   = sx_s3;
		rt_in.sy   = sy_s3;
		rt_in.ax   = ax_s3;
		rt_in.ay   = ay_s3;
		rt_in.rad  = sum_s3;
	end

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
		rt_t src;
		rt_t nxt;

		if (j == 0) begin : g_first
			assign src = rt_in;
		end else begin : g_next
			assign src = rt_s[j];
		end

		always_comb begin
			nxt = src;
			for (int i = 0; i < SQRT_PER_STAGE; i++) begin
				nxt = sqrt_step(nxt);
			end
		end

		always_ff @(posedge clk) begin
			if (ld[SQ_FIRST+j]) begin
				rt_s[j+1] <= nxt;
			end
		end
	end

	// divider stages: quotient = (mag << FRAC_BITS) / len
	dv_t dv_in;
	dv_t dv_s [1:DIV_STAGES];

	always_comb begin
		dv_in       = '0;
		dv_in.sx    = rt_s[SQRT_STAGES].sx;
		dv_in.sy    = rt_s[SQRT_STAGES].sy;
		dv_in.len   = rt_s[SQRT_STAGES].root;
		dv_in.rem_x = {1'b0, rt_s[SQRT_STAGES].ax[COMP_W-1:1]};
		dv_in.rem_y = {1'b0, rt_s[SQRT_STAGES].ay[COMP_W-1:1]};
		dv_in.num_x = {rt_s[SQRT_STAGES].ax[0], {FRAC_BITS{1'b0}}};
		dv_in.num_y = {rt_s[SQRT_STAGES].ay[0], {FRAC_BITS{1'b0}}};
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		dv_t src;
		dv_t nxt;

		if (j == 0) begin : g_first
			assign src = dv_in;
		end else begin : g_next
			assign src = dv_s[j];
		end

		always_comb begin
			nxt = src;
			for (int i = 0; i < DIV_PER_STAGE; i++) begin
				nxt = div_step(nxt);
			end
		end

		always_ff @(posedge clk) begin
			if (ld[DIV_FIRST+j]) begin
				dv_s[j+1] <= nxt;
			end
		end
	end

	// output stage: null check and signs
	logic              is_null;
	logic [COMP_W-1:0] qx_ext, qy_ext;

	assign is_null = dv_s[DIV_STAGES].len <= null_limit_q;
	assign qx_ext  = {1'b0, dv_s[DIV_STAGES].q_x};
	assign qy_ext  = {1'b0, dv_s[DIV_STAGES].q_y};

	logic signed [COMP_W-1:0] ux_s17, uy_s17;
	logic        [LEN_W-1:0]  len_s17;
	logic                     nerr_s17;

	always_ff @(posedge clk) begin
		if (ld[NUM_STAGES]) begin
			len_s17  <= dv_s[DIV_STAGES].len;
			nerr_s17 <= is_null;
			if (is_null) begin
				ux_s17 <= '0;
				uy_s17 <= '0;
			end else begin
				ux_s17 <= dv_s[DIV_STAGES].sx ? -qx_ext : qx_ext;
				uy_s17 <= dv_s[DIV_STAGES].sy ? -qy_ext : qy_ext;
			end
		end
	end

	assign unit_x     = ux_s17;
	assign unit_y     = uy_s17;
	assign length     = len_s17;
	assign null_error = nerr_s17;

endmodule

`default_nettype wire

FILE: tb/vector2_normalize_check.sv
// vector2_normalize_check: watches the request, result and null_limit write channels,
// predicts each normalized vector and compares it field by field with what comes out
// depends on v2n_pkg for field widths; instantiated by tb/vector2_normalize_test.sv
`default_nettype none

module vector2_normalize_check
	import v2n_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_ready,
	input  wire logic signed [COMP_W-1:0] x_component,
	input  wire logic signed [COMP_W-1:0] y_component,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic signed [COMP_W-1:0] unit_x,
	input  wire logic signed [COMP_W-1:0] unit_y,
	input  wire logic        [LEN_W-1:0]  length,
	input  wire logic                     null_error,
	input  wire logic                     cfg_valid,
	input  wire logic                     cfg_ready,
	input  wire logic        [LEN_W-1:0]  cfg_wdata,
	output int                            failures,
	output int                            outstanding,
	output int                            results_seen,
	output int                            nulls_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam int PRINT_CAP = 25;

	typedef struct {
		logic signed [COMP_W-1:0] req_x;
		logic signed [COMP_W-1:0] req_y;
		logic signed [COMP_W-1:0] ux;
		logic signed [COMP_W-1:0] uy;
		logic        [LEN_W-1:0]  len;
		logic                     is_null;
	} unit_vector_t;

	logic [LEN_W-1:0] null_limit_copy;
	unit_vector_t     expected_units[$];

	initial begin
		failures     = 0;
		outstanding  = 0;
		results_seen = 0;
		nulls_seen   = 0;
	end

	function automatic unit_vector_t normalize_vector(input logic signed [COMP_W-1:0] vx,
		input logic signed [COMP_W-1:0] vy, input logic [LEN_W-1:0] limit);
		unit_vector_t r;
		longint       ax;
		longint       ay;
		longint       sq;
		longint       root;
		longint       trial;
		longint       qx;
		longint       qy;
		int           b;
		r.req_x = vx;
		r.req_y = vy;
		ax      = (vx < 0) ? -longint'(vx) : longint'(vx);
		ay      = (vy < 0) ? -longint'(vy) : longint'(vy);
		sq      = ax * ax + ay * ay;
		root    = 0;
		for (b = LEN_W - 1; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= sq)
				root = trial;
		end
		r.len     = LEN_W'(root);
		r.is_null = (root <= longint'(limit));
		if (r.is_null) begin
			r.ux = '0;
			r.uy = '0;
		end else begin
			qx   = ax * Q_ONE / root;
			qy   = ay * Q_ONE / root;
			r.ux = (vx < 0) ? COMP_W'(-qx) : COMP_W'(qx);
			r.uy = (vy < 0) ? COMP_W'(-qy) : COMP_W'(qy);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want,
		input unit_vector_t req);
		if (failures < PRINT_CAP)
			$display("%0t mismatch %s: got %0d expected %0d for request x=%0d y=%0d",
				$realtime, what, got, want, req.req_x, req.req_y);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		unit_vector_t want;
		if (!arst_n) begin
			null_limit_copy = '0;
			expected_units.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				null_limit_copy = cfg_wdata;
			if (in_valid && in_ready)
				expected_units.push_back(normalize_vector(x_component, y_component,
					null_limit_copy));
			if (out_valid && out_ready) begin
				results_seen++;
				if (null_error)
					nulls_seen++;
				if (expected_units.size() == 0) begin
					want = '{default: '0};
					report_mismatch("result with no request pending", length, 0, want);
				end else begin
					want = expected_units.pop_front();
					if (unit_x !== want.ux)
						report_mismatch("unit_x", unit_x, want.ux, want);
					if (unit_y !== want.uy)
						report_mismatch("unit_y", unit_y, want.uy, want);
					if (length !== want.len)
						report_mismatch("length", length, want.len, want);
					if (null_error !== want.is_null)
						report_mismatch("null_error", null_error, want.is_null, want);
				end
			end
			outstanding = expected_units.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/vector2_normalize_test.sv
// vector2_normalize_test: clock, reset and stimulus for vector2_normalize with verdict
// depends on v2n_pkg, design/vector2_normalize.sv and tb/vector2_normalize_check.sv
`default_nettype none

module vector2_normalize_test;
	timeunit 1ns;
	timeprecision 1ps;
	import v2n_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 160;
	localparam int PHASES       = 6;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [COMP_W-1:0] x_component = '0;
	logic signed [COMP_W-1:0] y_component = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [COMP_W-1:0] unit_x;
	logic signed [COMP_W-1:0] unit_y;
	logic        [LEN_W-1:0]  length;
	logic                     null_error;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic        [LEN_W-1:0]  cfg_wdata   = '0;

	int failures;
	int outstanding;
	int results_seen;
	int nulls_seen;

	bit sender_idles    = 1'b1;
	bit receiver_stalls = 1'b1;
	int stall_left      = 0;
	int stall_pick;
	int vectors_sent    = 0;
	int limit_writes    = 0;
	int cycle_count     = 0;
	int current_limit   = 0;

	vector2_normalize uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_component(x_component),
		.y_component(y_component),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit_x     (unit_x),
		.unit_y     (unit_y),
		.length     (length),
		.null_error (null_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_wdata  (cfg_wdata)
	);

	vector2_normalize_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.x_component (x_component),
		.y_component (y_component),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.length      (length),
		.null_error  (null_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_wdata   (cfg_wdata),
		.failures    (failures),
		.outstanding (outstanding),
		.results_seen(results_seen),
		.nulls_seen  (nulls_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL vector2_normalize");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!receiver_stalls) begin
			out_ready <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 65) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = (stall_pick < 93) ? $urandom_range(0, 3) : $urandom_range(10, 50);
			end
		end
	end

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_vector(input int vx, input int vy);
		int gap;
		gap = sender_idles ? sender_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		x_component <= COMP_W'(vx);
		y_component <= COMP_W'(vy);
		do begin
			@(posedge clk);
		end while (!in_ready);
		vectors_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_null_limit(input int lim);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_wdata <= LEN_W'(lim);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		current_limit = lim;
		limit_writes++;
	endtask

	task automatic send_random_vector();
		int pick;
		int span;
		int vx;
		int vy;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			vx = int'($urandom_range(0, 65535)) - 32768;
			vy = int'($urandom_range(0, 65535)) - 32768;
		end else if (pick < 55) begin
			vx = int'($urandom_range(0, 48)) - 24;
			vy = int'($urandom_range(0, 48)) - 24;
		end else if (pick < 70) begin
			span = (current_limit + 2 > 32767) ? 32767 : current_limit + 2;
			vx   = $urandom_range(0, span);
			vy   = $urandom_range(0, 3);
			if ($urandom_range(0, 1))
				vx = -vx;
			if ($urandom_range(0, 1))
				vy = -vy;
			if ($urandom_range(0, 1)) begin
				span = vx;
				vx   = vy;
				vy   = span;
			end
		end else if (pick < 80) begin
			case ($urandom_range(0, 4))
				0: vx = -32768;
				1: vx = 32767;
				2: vx = 0;
				3: vx = -1;
				default: vx = 1;
			endcase
			case ($urandom_range(0, 4))
				0: vy = -32768;
				1: vy = 32767;
				2: vy = 0;
				3: vy = -1;
				default: vy = 1;
			endcase
		end else begin
			vx = int'($urandom_range(0, 2047)) - 1024;
			vy = int'($urandom_range(0, 2047)) - 1024;
		end
		send_vector(vx, vy);
	endtask

	initial begin
		int phase_limit;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// reset null_limit is zero
		send_vector(0, 0);
		send_vector(1, 0);
		send_vector(0, -1);
		send_vector(-1, -1);
		send_vector(32767, 32767);
		send_vector(-32768, -32768);
		send_vector(-32768, 0);
		send_vector(0, 32767);
		send_vector(-32768, 32767);
		send_vector(3, 4);
		send_vector(-3, -4);
		send_vector(21845, -21846);
		send_vector(1, -32768);
		send_vector(-7, 24);

		write_null_limit(1);
		send_vector(1, 1);
		send_vector(2, 0);
		write_null_limit(65535);
		send_vector(-32768, -32768);
		send_vector(5, 5);
		write_null_limit(46340);
		send_vector(-32768, -32768);
		send_vector(32767, -32767);
		write_null_limit(46339);
		send_vector(-32768, -32768);
		send_vector(32767, 32767);
		send_vector(-32768, 32767);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_limit = 0;
				1: phase_limit = $urandom_range(1, 12);
				2: phase_limit = $urandom_range(13, 400);
				3: phase_limit = $urandom_range(0, 65535);
				4: phase_limit = 46339;
				default: phase_limit = $urandom_range(0, 3);
			endcase
			write_null_limit(phase_limit);
			sender_idles    = (phase != 0) && (phase != 4);
			receiver_stalls = (phase != 0) && (phase != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2 && phase == 3)
					drain_results();
				send_random_vector();
			end
		end
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;

		drain_results();
		repeat (2 * NUM_STAGES) @(negedge clk);
		$display("covered %0d vectors (%0d results, %0d null) over %0d null_limit writes",
			vectors_sent, results_seen, nulls_seen, limit_writes);
		$display("axis, diagonal, extreme and near-threshold vectors with random idling");
		if (failures == 0)
			$display("PASS vector2_normalize");
		else
			$display("FAIL vector2_normalize");
		$finish;
	end

endmodule

`default_nettype wire
